/* src/ssdd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdd_pkg
// shared widths, codes and helpers for the sample to decimal digits block
// ----------------------------------------------------------------------------
package ssdd_pkg;

  localparam int unsigned SAMPLE_W        = 10;
  localparam int unsigned CH_W            = 2;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned VALUE_W         = 14;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  localparam int unsigned TEMP_SPAN  = 10000;
  localparam int unsigned TEMP_MID   = 4995;
  localparam int unsigned TEMP_HI    = 5000;
  localparam int unsigned TEMP_LO    = 4994;
  localparam int unsigned HUM_SPAN   = 1000;
  localparam int unsigned PRS_OFFSET = 54;
  localparam int unsigned PRS_GAIN   = 2570;
  localparam int unsigned PRS_DIV    = 968;
  localparam int unsigned WIND_SPAN  = 3000;
  localparam int unsigned VALUE_MAX  = 9999;

  localparam logic [CH_W-1:0] CH_TEMP = 2'd0;
  localparam logic [CH_W-1:0] CH_HUM  = 2'd1;
  localparam logic [CH_W-1:0] CH_PRS  = 2'd2;
  localparam logic [CH_W-1:0] CH_WIND = 2'd3;

  typedef enum logic [1:0] {
    SIGN_BLANK = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_code_t;

  // side data that travels alongside the value through the pipeline
  typedef struct packed {
    logic [CH_W-1:0] channel;
    sign_code_t      sign;
  } item_tag_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rest;
  } digit_split_t;

  // one decimal digit by a bank of nine parallel compares
  function automatic digit_split_t split_digit(input logic [VALUE_W-1:0] v,
                                               input int unsigned weight);
    digit_split_t       res;
    logic [VALUE_W-1:0] step;
    res.digit = '0;
    res.rest  = v;
    for (int unsigned k = 1; k <= 9; k++) begin
      step = VALUE_W'(k * weight);
      if (v >= step) begin
        res.digit = DIGIT_W'(k);
        res.rest  = v - step;
      end
    end
    return res;
  endfunction

endpackage

/* src/sensor_sample_to_decimal_digits.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_sample_to_decimal_digits
// scales a converter sample per sensor channel and splits it into digits
// ----------------------------------------------------------------------------
// Takes one item (channel, sample) in every clock cycle: busy is never raised,
// so start alone launches an item. Each item gives exactly one result out of
// the pipeline, shown for a single cycle with out_valid high. The receiver
// cannot stall, so results must be captured on the cycle they appear. The
// pipeline registers, in order, are: gain multiply, temperature offset,
// reciprocal multiply, remainder multiply, correction, then three digit
// compare stages. Only the low SAMPLE_BITS bits of the sample are used and
// the value is clamped at 9999.
// ----------------------------------------------------------------------------
module sensor_sample_to_decimal_digits #(
  parameter int unsigned SAMPLE_BITS = ssdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssdd_pkg::CH_W-1:0]     in_channel,
  input  logic [ssdd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  output logic [ssdd_pkg::CH_W-1:0]     out_channel_out,
  output logic [1:0]                    out_sign_code,
  output logic [ssdd_pkg::DIGIT_W-1:0]  out_thousands_digit,
  output logic [ssdd_pkg::DIGIT_W-1:0]  out_hundreds_digit,
  output logic [ssdd_pkg::DIGIT_W-1:0]  out_tens_digit,
  output logic [ssdd_pkg::DIGIT_W-1:0]  out_units_digit
);
  import ssdd_pkg::*;

  // full scale and the widest numerator (temperature span times full scale)
  localparam int unsigned FULL_SCALE = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned NUM_W      = $clog2(TEMP_SPAN * FULL_SCALE + 1);
  // bits of the sample port that take part
  localparam int unsigned SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  localparam logic [NUM_W-1:0] T_HI  = NUM_W'(TEMP_HI * FULL_SCALE);
  localparam logic [NUM_W-1:0] T_LO  = NUM_W'(TEMP_LO * FULL_SCALE);
  localparam logic [NUM_W-1:0] T_MID = NUM_W'(TEMP_MID * FULL_SCALE);
  localparam logic [SW-1:0]    OFFS  = SW'(PRS_OFFSET);

  logic accept;

  // no back pressure anywhere, so the pipeline always moves
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------- stage 1: per channel gain multiply ----------------
  logic [SW-1:0]    s_in, d_in;
  logic [NUM_W-1:0] gain, prod1_nxt, prod1_r;
  logic [CH_W-1:0]  ch1_r;
  logic             v1_r;

  always_comb begin
    s_in = in_sample[SW-1:0];
    d_in = s_in;
    unique case (in_channel)
      CH_TEMP: gain = NUM_W'(TEMP_SPAN);
      CH_HUM:  gain = NUM_W'(HUM_SPAN);
      CH_PRS: begin
        gain = NUM_W'(PRS_GAIN);
        // clamp below the pressure offset instead of wrapping
        d_in = (s_in >= OFFS) ? s_in - OFFS : '0;
      end
      CH_WIND: gain = NUM_W'(WIND_SPAN);
      default: gain = '0;
    endcase
    prod1_nxt = NUM_W'(d_in) * gain;
  end

  // ---------------- stage 2: temperature offset and sign ----------------
  logic [NUM_W-1:0] num2_r, num2_nxt;
  item_tag_t        tag2_r, tag2_nxt;
  logic             v2_r;

  always_comb begin
    num2_nxt         = prod1_r;
    tag2_nxt.channel = ch1_r;
    tag2_nxt.sign    = SIGN_BLANK;
    if (ch1_r == CH_TEMP) begin
      priority if (prod1_r > T_HI) begin
        num2_nxt      = prod1_r - T_MID;
        tag2_nxt.sign = SIGN_PLUS;
      end else if (prod1_r < T_LO) begin
        num2_nxt      = T_MID - prod1_r;
        tag2_nxt.sign = SIGN_MINUS;
      end else begin
        // dead band around the midpoint shows a blank zero
        num2_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
    prod1_r <= prod1_nxt;
    ch1_r   <= in_channel;
    num2_r  <= num2_nxt;
    tag2_r  <= tag2_nxt;
  end

  // ---------------- stages 3 to 5: constant division ----------------
  logic               v5;
  logic [VALUE_W-1:0] value5;
  item_tag_t          tag5;

  ssdd_const_div #(
    .NUM_W      (NUM_W),
    .FULL_SCALE (FULL_SCALE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_num    (num2_r),
    .in_tag    (tag2_r),
    .out_valid (v5),
    .out_value (value5),
    .out_tag   (tag5)
  );

  // ---------------- stages 6 to 8: decimal digits ----------------
  item_tag_t tag8;

  ssdd_digits u_digits (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (v5),
    .in_value      (value5),
    .in_tag        (tag5),
    .out_valid     (out_valid),
    .out_tag       (tag8),
    .out_thousands (out_thousands_digit),
    .out_hundreds  (out_hundreds_digit),
    .out_tens      (out_tens_digit),
    .out_units     (out_units_digit)
  );

  assign out_channel_out = tag8.channel;
  assign out_sign_code   = tag8.sign;

endmodule

/* src/ssdd_const_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdd_const_div
// three stage divide by full scale or by the pressure divisor, saturated
// ----------------------------------------------------------------------------
module ssdd_const_div #(
  parameter int unsigned NUM_W      = 24,
  parameter int unsigned FULL_SCALE = 1023
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [NUM_W-1:0]             in_num,
  input  ssdd_pkg::item_tag_t          in_tag,
  output logic                         out_valid,
  output logic [ssdd_pkg::VALUE_W-1:0] out_value,
  output ssdd_pkg::item_tag_t          out_tag
);
  import ssdd_pkg::*;

  localparam longint unsigned M_FS  = (64'd1 << NUM_W) / FULL_SCALE;
  localparam longint unsigned M_PRS = (64'd1 << NUM_W) / PRS_DIV;
  localparam logic [NUM_W-1:0] RECIP_FS  = NUM_W'(M_FS);
  localparam logic [NUM_W-1:0] RECIP_PRS = NUM_W'(M_PRS);
  localparam logic [NUM_W-1:0] DEN_FS    = NUM_W'(FULL_SCALE);
  localparam logic [NUM_W-1:0] DEN_PRS   = NUM_W'(PRS_DIV);
  localparam logic [NUM_W-1:0] SAT       = NUM_W'(VALUE_MAX);

  // stage 1: quotient estimate, low by at most one
  logic [2*NUM_W-1:0] est_prod;
  logic               v1_r;
  logic [NUM_W-1:0]   q1_r, q1_nxt, num1_r, den1_r, den1_nxt;
  item_tag_t          tag1_r;

  always_comb begin
    if (in_tag.channel == CH_PRS) begin
      est_prod = {{NUM_W{1'b0}}, in_num} * {{NUM_W{1'b0}}, RECIP_PRS};
      den1_nxt = DEN_PRS;
    end else begin
      est_prod = {{NUM_W{1'b0}}, in_num} * {{NUM_W{1'b0}}, RECIP_FS};
      den1_nxt = DEN_FS;
    end
    q1_nxt = est_prod[2*NUM_W-1:NUM_W];
  end

  // stage 2: remainder of the estimate
  logic [2*NUM_W-1:0] back_prod;
  logic               v2_r;
  logic [NUM_W-1:0]   q2_r, rem2_r, rem2_nxt, den2_r;
  item_tag_t          tag2_r;

  always_comb begin
    back_prod = {{NUM_W{1'b0}}, q1_r} * {{NUM_W{1'b0}}, den1_r};
    rem2_nxt  = num1_r - back_prod[NUM_W-1:0];
  end

  // stage 3: correction and clamp to four digits
  logic [NUM_W-1:0]   q3;
  logic [VALUE_W-1:0] value3_r, value3_nxt;
  logic               v3_r;
  item_tag_t          tag3_r;

  always_comb begin
    q3 = (rem2_r >= den2_r) ? q2_r + NUM_W'(1) : q2_r;
    if (q3 > SAT) begin
      value3_nxt = VALUE_W'(VALUE_MAX);
    end else begin
      value3_nxt = q3[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    q1_r     <= q1_nxt;
    num1_r   <= in_num;
    den1_r   <= den1_nxt;
    tag1_r   <= in_tag;
    q2_r     <= q1_r;
    rem2_r   <= rem2_nxt;
    den2_r   <= den1_r;
    tag2_r   <= tag1_r;
    value3_r <= value3_nxt;
    tag3_r   <= tag2_r;
  end

  assign out_valid = v3_r;
  assign out_value = value3_r;
  assign out_tag   = tag3_r;

endmodule

/* src/ssdd_digits.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdd_digits
// three stage binary to four decimal digits
// ----------------------------------------------------------------------------
module ssdd_digits (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [ssdd_pkg::VALUE_W-1:0] in_value,
  input  ssdd_pkg::item_tag_t          in_tag,
  output logic                         out_valid,
  output ssdd_pkg::item_tag_t          out_tag,
  output logic [ssdd_pkg::DIGIT_W-1:0] out_thousands,
  output logic [ssdd_pkg::DIGIT_W-1:0] out_hundreds,
  output logic [ssdd_pkg::DIGIT_W-1:0] out_tens,
  output logic [ssdd_pkg::DIGIT_W-1:0] out_units
);
  import ssdd_pkg::*;

  digit_split_t       th_nxt, hu_nxt, te_nxt;
  logic               va_r, vb_r, vc_r;
  item_tag_t          taga_r, tagb_r, tagc_r;
  logic [DIGIT_W-1:0] tha_r, thb_r, thc_r, hub_r, huc_r, tec_r, unc_r;
  logic [VALUE_W-1:0] resta_r, restb_r;

  always_comb begin
    th_nxt = split_digit(in_value, 1000);
    hu_nxt = split_digit(resta_r, 100);
    te_nxt = split_digit(restb_r, 10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    tha_r   <= th_nxt.digit;
    resta_r <= th_nxt.rest;
    taga_r  <= in_tag;
    thb_r   <= tha_r;
    hub_r   <= hu_nxt.digit;
    restb_r <= hu_nxt.rest;
    tagb_r  <= taga_r;
    thc_r   <= thb_r;
    huc_r   <= hub_r;
    tec_r   <= te_nxt.digit;
    unc_r   <= te_nxt.rest[DIGIT_W-1:0];
    tagc_r  <= tagb_r;
  end

  assign out_valid     = vc_r;
  assign out_tag       = tagc_r;
  assign out_thousands = thc_r;
  assign out_hundreds  = huc_r;
  assign out_tens      = tec_r;
  assign out_units     = unc_r;

endmodule

/* sim/sensor_sample_to_decimal_digits_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_sample_to_decimal_digits_tb
// self-checking bench for the sample to decimal digits converter
// ----------------------------------------------------------------------------
// Feeds (channel, sample) items through the start/busy port, first a short
// directed list around the range ends and the sign and clamp boundaries,
// then random items in three idling phases. A scoreboard works out the
// display reading for every accepted item and compares each strobed result
// against the oldest reading still due, field by field.
// ----------------------------------------------------------------------------
module sensor_sample_to_decimal_digits_tb;
  import ssdd_pkg::*;

  localparam int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF;
  localparam int unsigned PIPE_LATENCY  = 8;
  localparam int unsigned DRAIN_CYCLES  = 2 * PIPE_LATENCY;
  localparam int unsigned STALL_LIMIT   = 400;
  localparam int unsigned N_DIRECTED    = 22;

  // one displayed reading: channel, sign and four decimal digits
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    sign_code_t         sign;
    logic [DIGIT_W-1:0] thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } reading_t;

  // holds the readings still due from the block and checks each one
  class display_ledger;
    reading_t    due_readings[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // scale one sample to its display reading in exact integer arithmetic
    function reading_t scale_reading(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      int unsigned full_scale;
      int unsigned s;
      int unsigned scaled;
      int unsigned val;
      reading_t    r;
      full_scale = (1 << SAMPLE_BITS) - 1;
      s          = int'(smp) & full_scale;
      val        = 0;
      r.sign     = SIGN_BLANK;
      case (ch)
        CH_TEMP: begin
          // compare s*10000/fs against the band edges without dividing
          scaled = s * TEMP_SPAN;
          if (scaled > TEMP_HI * full_scale) begin
            val    = (scaled - TEMP_MID * full_scale) / full_scale;
            r.sign = SIGN_PLUS;
          end else if (scaled < TEMP_LO * full_scale) begin
            val    = (TEMP_MID * full_scale - scaled) / full_scale;
            r.sign = SIGN_MINUS;
          end
        end
        CH_HUM: val = (s * HUM_SPAN) / full_scale;
        CH_PRS: begin
          // below the offset the reading clamps to zero
          if (s >= PRS_OFFSET) val = (PRS_GAIN * (s - PRS_OFFSET)) / PRS_DIV;
        end
        default: val = (s * WIND_SPAN) / full_scale;
      endcase
      if (val > VALUE_MAX) val = VALUE_MAX;
      r.channel   = ch;
      r.thousands = DIGIT_W'(val / 1000);
      r.hundreds  = DIGIT_W'((val % 1000) / 100);
      r.tens      = DIGIT_W'((val % 100) / 10);
      r.units     = DIGIT_W'(val % 10);
      return r;
    endfunction

    function void note_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      due_readings.push_back(scale_reading(ch, smp));
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (due_readings.size() == 0) begin
        $error("result strobed with no item outstanding");
        failures++;
        return;
      end
      want = due_readings.pop_front();
      check_field("channel_out", want.channel, got.channel);
      check_field("sign_code", want.sign, got.sign);
      check_field("thousands_digit", want.thousands, got.thousands);
      check_field("hundreds_digit", want.hundreds, got.hundreds);
      check_field("tens_digit", want.tens, got.tens);
      check_field("units_digit", want.units, got.units);
    endfunction

    function int unsigned pending();
      return due_readings.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CH_W-1:0]       in_channel;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic [CH_W-1:0]       out_channel_out;
  logic [1:0]            out_sign_code;
  logic [DIGIT_W-1:0]    out_thousands_digit;
  logic [DIGIT_W-1:0]    out_hundreds_digit;
  logic [DIGIT_W-1:0]    out_tens_digit;
  logic [DIGIT_W-1:0]    out_units_digit;

  display_ledger board;

  // directed list: range ends, temperature sign band edges, pressure offset,
  // blank sign on the other channels and alternating bit patterns
  int unsigned directed_ch[N_DIRECTED] = '{
    0, 0, 0, 0, 0, 0, 0,
    1, 1, 1,
    2, 2, 2, 2, 2, 2,
    3, 3, 3, 3,
    0, 1
  };
  int unsigned directed_smp[N_DIRECTED] = '{
    0, 1023, 509, 510, 511, 512, 513,
    0, 1, 1023,
    0, 53, 54, 55, 1022, 1023,
    0, 1023, 341, 682,
    'h2AA, 'h155
  };

  sensor_sample_to_decimal_digits #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_channel          (in_channel),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_channel_out     (out_channel_out),
    .out_sign_code       (out_sign_code),
    .out_thousands_digit (out_thousands_digit),
    .out_hundreds_digit  (out_hundreds_digit),
    .out_tens_digit      (out_tens_digit),
    .out_units_digit     (out_units_digit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // present one item and hold it until the block takes it
  task automatic offer_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    start      <= 1'b1;
    in_channel <= ch;
    in_sample  <= smp;
    do @(posedge clk); while (busy);
  endtask

  // sender gap: start low, junk on the data ports
  task automatic hold_off(input int unsigned cycles);
    start      <= 1'b0;
    in_channel <= CH_W'($urandom_range(3));
    in_sample  <= SAMPLE_W'($urandom_range(1023));
    repeat (cycles) @(posedge clk);
  endtask

  // mostly uniform, with extra weight near the sign band and pressure offset
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return SAMPLE_W'($urandom_range(518, 505));
    if (roll == 1) return SAMPLE_W'($urandom_range(58, 50));
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  task automatic feed_random(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned n = 0; n < count; n++) begin
      // each cycle the sender idles with the given odds
      while ($urandom_range(99) < idle_pct) hold_off(1);
      offer_item(CH_W'($urandom_range(3)), pick_sample());
    end
  endtask

  // sample both the input side and the result side at the edge, before any driven update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_item(in_channel, in_sample);
      if (out_valid) begin
        board.check_reading('{channel:   out_channel_out,
                              sign:      sign_code_t'(out_sign_code),
                              thousands: out_thousands_digit,
                              hundreds:  out_hundreds_digit,
                              tens:      out_tens_digit,
                              units:     out_units_digit});
      end
    end
  end

  // watchdog: too many cycles with neither an item taken nor a result shown
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("sensor_sample_to_decimal_digits test failed");
    $finish;
  end

  initial begin
    board      = new();
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_channel <= '0;
    in_sample  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < N_DIRECTED; i++) begin
      offer_item(CH_W'(directed_ch[i]), SAMPLE_W'(directed_smp[i]));
    end

    // light sender gaps, then heavy gaps, then back to back
    feed_random(317, 30);
    feed_random(317, 84);
    feed_random(316, 0);
    start <= 1'b0;

    // let the pipeline drain, then a little longer to catch stray strobes
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0) begin
      $display("sensor_sample_to_decimal_digits test passed");
    end else begin
      $display("sensor_sample_to_decimal_digits test failed");
    end
    $finish;
  end

endmodule
